// ===== hw/rtl/qlvs_pkg.sv =====
// ----------------------------------------------------------------------------
// qlvs_pkg: shared types and constants of the Q-learning victim selector
// Request and result beats, configuration register indexes, reset values,
// fixed-point constants and the LFSR step.
// ----------------------------------------------------------------------------
package qlvs_pkg;

    localparam int WAYS_DEFAULT    = 16;
    localparam int Q_WIDTH_DEFAULT = 16;
    localparam int Q_FRAC          = 10;
    localparam int COEF_W          = 16;
    localparam int LFSR_W          = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPLORE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEARN_RATE        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISCOUNT          = 2'd2;

    localparam logic [COEF_W-1:0] EXPLORE_THRESHOLD_RESET = 16'd6554;
    localparam logic [COEF_W-1:0] LEARN_RATE_RESET        = 16'd6554;
    localparam logic [COEF_W-1:0] DISCOUNT_RESET          = 16'd58982;

    localparam logic OP_CHOOSE = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] valid_mask;
        logic [3:0]  way;
        logic        hit;
    } request_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       explored;
    } result_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/qlvs_mulrnd.sv =====
// ----------------------------------------------------------------------------
// qlvs_mulrnd: shared coefficient multiplier with round half up
// Registers coef * operand, then presents round(product / 2^16) as the
// floor of (product + 2^15) shifted right by 16.
// ----------------------------------------------------------------------------
module qlvs_mulrnd #(
    parameter int OPW = qlvs_pkg::Q_WIDTH_DEFAULT + 2
) (
    input  logic                             clk,
    input  logic [qlvs_pkg::COEF_W-1:0]      coef,
    input  logic signed [OPW-1:0]            operand,
    output logic signed [OPW:0]              rounded
);

    localparam int CW = qlvs_pkg::COEF_W;
    localparam int PW = OPW + CW + 1;
    localparam logic signed [PW-1:0] HALF = {{(PW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] biased;

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, coef}) * operand;
    end

    assign biased  = prod_reg + HALF;
    assign rounded = $signed(biased[PW-1:CW]);

endmodule

// ===== hw/rtl/q_learning_victim_selector.sv =====
// ----------------------------------------------------------------------------
// q_learning_victim_selector: cache victim choice by tabular Q-learning
// Keeps a Q table per set occupancy and way, picks a victim greedily or by
// LFSR exploration, and learns from hit/miss updates in fixed point.
// ----------------------------------------------------------------------------
//
//  channel   signals                          beat taken when
//  --------  -------------------------------  ------------------------
//  request   start, busy, request             start && !busy
//  result    done, result                     done (one cycle, no stall)
//  config    cfg_write, cfg_index, cfg_data   cfg_write
//
//  Greedy choose: one table read per way, each compared with the running best.
//  Exploring choose: a reciprocal multiply, then a remainder subtract.
//  Update: a scan, then two passes through one multiplier;
//  an update naming a way at or above WAYS is taken but leaves busy low.
//  After reset all (WAYS+1)*WAYS table entries are cleared one entry a cycle,
//  with busy high. The receiver cannot stall; done lasts one cycle.
// ----------------------------------------------------------------------------
module q_learning_victim_selector #(
    parameter int WAYS    = qlvs_pkg::WAYS_DEFAULT,
    parameter int Q_WIDTH = qlvs_pkg::Q_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  qlvs_pkg::request_t                  request,
    output logic                                done,
    output qlvs_pkg::result_t                   result,
    input  logic                                cfg_write,
    input  logic [qlvs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [qlvs_pkg::COEF_W-1:0]         cfg_data
);

    localparam int DEPTH  = (WAYS + 1) * WAYS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(WAYS);
    localparam int ROW_W  = $clog2(WAYS + 1);
    localparam int OPW    = Q_WIDTH + 2;
    localparam int LW     = qlvs_pkg::LFSR_W;
    localparam int MCW    = 1;
    localparam int CW     = qlvs_pkg::COEF_W;

    localparam int RECIP_SH = 21;
    localparam logic [RECIP_SH-1:0] RECIP =
        RECIP_SH'(((64'd1 << RECIP_SH) + 64'(WAYS) - 64'd1) / 64'(WAYS));

    localparam logic [15:0] WAY_MASK = 16'((32'd1 << WAYS) - 1);
    localparam logic signed [OPW:0] REWARD_POS = (OPW+1)'(1 << qlvs_pkg::Q_FRAC);
    localparam logic signed [OPW:0] REWARD_NEG = -REWARD_POS;
    localparam logic signed [OPW:0] Q_MAX =
        $signed({{(OPW+2-Q_WIDTH){1'b0}}, {(Q_WIDTH-1){1'b1}}});
    localparam logic signed [OPW:0] Q_MIN = ~Q_MAX;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_MUL2  = 3'd6;
    localparam logic [2:0] S_WRITE = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [IDX_W:0]      scan_cnt_reg, scan_cnt_next;
    logic [MCW-1:0]      mod_cnt_reg, mod_cnt_next;
    logic [LW-1:0]       lfsr_reg, lfsr_next;
    logic [CW-1:0]       explore_thr_reg, learn_rate_reg, discount_reg;
    logic                done_reg, done_next;

    logic                opcode_reg;
    logic                hit_reg;
    logic [3:0]          upd_way_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [LW-1:0]       mod_val_reg;
    logic [LW-1:0]       quo_reg;
    logic signed [Q_WIDTH-1:0] best_q_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic signed [Q_WIDTH-1:0] q_cur_reg;
    logic signed [OPW-1:0] e_reg;
    qlvs_pkg::result_t   result_reg;

    logic [Q_WIDTH-1:0]  mem [DEPTH];
    logic [Q_WIDTH-1:0]  mem_rd_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [Q_WIDTH-1:0]  mem_wdata;

    logic                accept;
    logic                way_ok;
    logic [ROW_W-1:0]    row;
    logic [LW-1:0]       step1, step2;
    logic                explore;
    logic [IDX_W-1:0]    rd_idx;
    logic                cmp_on;
    logic [IDX_W-1:0]    cmp_idx;
    logic signed [Q_WIDTH-1:0] rd_q;
    logic                take;
    logic [IDX_W-1:0]    best_idx_cur;
    logic [LW+RECIP_SH-1:0] quo_prod;
    logic [LW-1:0]       rem_full;
    logic [IDX_W-1:0]    rem_next;
    logic [CW-1:0]       mul_coef;
    logic signed [OPW-1:0] mul_operand;
    logic signed [OPW:0] mul_rnd;
    logic signed [OPW:0] reward;
    logic signed [OPW:0] e_sum;
    logic signed [OPW:0] q_sum;
    logic signed [Q_WIDTH-1:0] q_sat;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign way_ok = ({1'b0, request.way} < 5'(WAYS));
    assign row    = ROW_W'($countones(request.valid_mask & WAY_MASK));
    assign step1  = qlvs_pkg::lfsr_step(lfsr_reg);
    assign step2  = qlvs_pkg::lfsr_step(step1);
    assign explore = (step1 < explore_thr_reg);

    // scan: read way c in count c, compare way c-1 against the running best
    assign rd_idx  = (scan_cnt_reg < (IDX_W+1)'(WAYS)) ? scan_cnt_reg[IDX_W-1:0] : '0;
    assign cmp_on  = (state_reg == S_SCAN) && (scan_cnt_reg != '0);
    assign cmp_idx = IDX_W'(scan_cnt_reg - 1'b1);
    assign rd_q    = $signed(mem_rd_reg);
    assign take    = (scan_cnt_reg == (IDX_W+1)'(1)) || (rd_q > best_q_reg);
    assign best_idx_cur = (cmp_on && take) ? cmp_idx : best_idx_reg;

    assign quo_prod = mod_val_reg * RECIP;
    assign rem_full = mod_val_reg - LW'(quo_reg * LW'(WAYS));
    assign rem_next = IDX_W'(rem_full);

    assign mul_coef    = (state_reg == S_MUL2) ? learn_rate_reg : discount_reg;
    assign mul_operand = (state_reg == S_MUL2) ? e_reg : OPW'(best_q_reg);

    qlvs_mulrnd #(
        .OPW (OPW)
    ) u_mulrnd (
        .clk     (clk),
        .coef    (mul_coef),
        .operand (mul_operand),
        .rounded (mul_rnd)
    );

    assign reward = hit_reg ? REWARD_POS : REWARD_NEG;
    assign e_sum  = reward + mul_rnd - (OPW+1)'(q_cur_reg);
    assign q_sum  = (OPW+1)'(q_cur_reg) + mul_rnd;
    assign q_sat  = (q_sum > Q_MAX) ? Q_WIDTH'(Q_MAX) :
                    (q_sum < Q_MIN) ? Q_WIDTH'(Q_MIN) : Q_WIDTH'(q_sum);

    assign mem_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg :
                       ADDR_W'(base_reg + ADDR_W'(upd_way_reg));
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : q_sat;
    assign mem_raddr = ADDR_W'(base_reg + ADDR_W'(rd_idx));

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        scan_cnt_next = scan_cnt_reg;
        mod_cnt_next  = mod_cnt_reg;
        lfsr_next     = lfsr_reg;
        done_next     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                scan_cnt_next = '0;
                mod_cnt_next  = '0;
                if (accept)
                begin
                    if (request.opcode == qlvs_pkg::OP_CHOOSE)
                    begin
                        if (explore)
                        begin
                            lfsr_next  = step2;
                            state_next = S_MOD;
                        end
                        else
                        begin
                            lfsr_next  = step1;
                            state_next = S_SCAN;
                        end
                    end
                    else if (way_ok)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == (IDX_W+1)'(WAYS))
                begin
                    if (opcode_reg == qlvs_pkg::OP_CHOOSE)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MOD:
            begin
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == '1)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MUL1:  state_next = S_SUM;
            S_SUM:   state_next = S_MUL2;
            S_MUL2:  state_next = S_WRITE;
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            scan_cnt_reg    <= '0;
            mod_cnt_reg     <= '0;
            lfsr_reg        <= qlvs_pkg::LFSR_SEED;
            done_reg        <= 1'b0;
            explore_thr_reg <= qlvs_pkg::EXPLORE_THRESHOLD_RESET;
            learn_rate_reg  <= qlvs_pkg::LEARN_RATE_RESET;
            discount_reg    <= qlvs_pkg::DISCOUNT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            scan_cnt_reg <= scan_cnt_next;
            mod_cnt_reg  <= mod_cnt_next;
            lfsr_reg     <= lfsr_next;
            done_reg     <= done_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    qlvs_pkg::CFG_EXPLORE_THRESHOLD: explore_thr_reg <= cfg_data;
                    qlvs_pkg::CFG_LEARN_RATE:        learn_rate_reg  <= cfg_data;
                    qlvs_pkg::CFG_DISCOUNT:          discount_reg    <= cfg_data;
                    default:                         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg  <= request.opcode;
            hit_reg     <= request.hit;
            upd_way_reg <= request.way;
            base_reg    <= ADDR_W'(row * WAYS);
            mod_val_reg <= step2;
        end
        if ((state_reg == S_MOD) && (mod_cnt_reg == '0))
        begin
            quo_reg <= quo_prod[LW+RECIP_SH-1:RECIP_SH];
        end
        if (cmp_on && take)
        begin
            best_q_reg   <= rd_q;
            best_idx_reg <= cmp_idx;
        end
        if (cmp_on && (4'(cmp_idx) == upd_way_reg))
        begin
            q_cur_reg <= rd_q;
        end
        if (state_reg == S_SUM)
        begin
            e_reg <= OPW'(e_sum);
        end
        if ((state_reg == S_SCAN) && (scan_cnt_reg == (IDX_W+1)'(WAYS)))
        begin
            result_reg.victim_way <= 4'(best_idx_cur);
            result_reg.explored   <= 1'b0;
        end
        if ((state_reg == S_MOD) && (mod_cnt_reg == '1))
        begin
            result_reg.victim_way <= 4'(rem_next);
            result_reg.explored   <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_raddr];
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, result.victim_way} < 5'(WAYS)))
        else $error("victim way out of range");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_SCAN || $past(state_reg) == S_MOD))
        else $error("result produced outside a choose");

    a_explored_source: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.explored) |-> ($past(state_reg) == S_MOD))
        else $error("explored result did not come from the random path");

endmodule

// ===== sim/qlvs_checker.sv =====
// ----------------------------------------------------------------------------
// qlvs_checker: result checker for the Q-learning victim selector
// Follows every accepted request and coefficient write, keeps its own Q table,
// LFSR and coefficients, predicts the victim of each choose beat and compares
// each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module qlvs_checker #(
    parameter int WAYS    = qlvs_pkg::WAYS_DEFAULT,
    parameter int Q_WIDTH = qlvs_pkg::Q_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  qlvs_pkg::request_t               request,
    input  logic                             done,
    input  qlvs_pkg::result_t                result,
    input  logic                             cfg_write,
    input  logic [qlvs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [qlvs_pkg::COEF_W-1:0]      cfg_data,
    output int unsigned                      fail_count,
    output int unsigned                      pending,
    output int unsigned                      results_checked,
    output int unsigned                      explored_seen
);

    import qlvs_pkg::*;

    localparam int     ROWS = WAYS + 1;
    localparam longint Q_HI = (longint'(1) <<< (Q_WIDTH - 1)) - 1;
    localparam longint Q_LO = -Q_HI - 1;

    logic signed [Q_WIDTH-1:0] q_table [ROWS][WAYS];
    logic [LFSR_W-1:0]         lfsr_model;
    logic [COEF_W-1:0]         explore_level;
    logic [COEF_W-1:0]         learn_gain;
    logic [COEF_W-1:0]         discount_gain;
    result_t                   victims_due [$];
    int unsigned               failures;
    int unsigned               results_seen;
    int unsigned               explored_count;

    function automatic int unsigned occupancy_of(input logic [15:0] mask);
        int unsigned n;
        n = 0;
        for (int i = 0; i < WAYS; i++)
        begin
            n += mask[i];
        end
        return n;
    endfunction

    function automatic logic [LFSR_W-1:0] shift_lfsr(input logic [LFSR_W-1:0] v);
        return {1'b0, v[LFSR_W-1:1]} ^ (v[0] ? LFSR_TAPS : '0);
    endfunction

    function automatic longint round_q16(input longint x);
        return (x + 32768) >>> 16;
    endfunction

    task automatic best_in_row(input int unsigned row, output int unsigned best,
                               output longint row_max);
        best = 0;
        row_max = q_table[row][0];
        for (int i = 1; i < WAYS; i++)
        begin
            if (q_table[row][i] > row_max)
            begin
                row_max = q_table[row][i];
                best = i;
            end
        end
    endtask

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        failures++;
    endtask

    task automatic predict(input request_t r);
        int unsigned row;
        int unsigned best;
        longint      row_max;
        longint      q;
        longint      reward;
        longint      g;
        longint      d;
        result_t     want;
        row = occupancy_of(r.valid_mask);
        if (r.opcode == OP_CHOOSE)
        begin
            lfsr_model = shift_lfsr(lfsr_model);
            if (lfsr_model < explore_level)
            begin
                lfsr_model = shift_lfsr(lfsr_model);
                want.victim_way = 4'(lfsr_model % WAYS);
                want.explored = 1'b1;
            end
            else
            begin
                best_in_row(row, best, row_max);
                want.victim_way = 4'(best);
                want.explored = 1'b0;
            end
            victims_due.push_back(want);
        end
        else if (r.way < WAYS)
        begin
            reward = r.hit ? (longint'(1) <<< Q_FRAC) : -(longint'(1) <<< Q_FRAC);
            q = q_table[row][r.way];
            best_in_row(row, best, row_max);
            g = round_q16(longint'(discount_gain) * row_max);
            d = round_q16(longint'(learn_gain) * (reward + g - q));
            q = q + d;
            if (q > Q_HI)
            begin
                q = Q_HI;
            end
            else if (q < Q_LO)
            begin
                q = Q_LO;
            end
            q_table[row][r.way] = Q_WIDTH'(q);
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (victims_due.size() == 0)
        begin
            report($sformatf("result beat way %0d explored %0d with nothing outstanding",
                             got.victim_way, got.explored));
            return;
        end
        want = victims_due.pop_front();
        results_seen++;
        if (got.explored)
        begin
            explored_count++;
        end
        if (got.victim_way !== want.victim_way)
        begin
            report($sformatf("victim_way expected %0d, got %0d",
                             want.victim_way, got.victim_way));
        end
        if (got.explored !== want.explored)
        begin
            report($sformatf("explored expected %0d, got %0d", want.explored, got.explored));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    q_table[r][w] = '0;
                end
            end
            lfsr_model = LFSR_SEED;
            explore_level = EXPLORE_THRESHOLD_RESET;
            learn_gain = LEARN_RATE_RESET;
            discount_gain = DISCOUNT_RESET;
            victims_due.delete();
            failures = 0;
            results_seen = 0;
            explored_count = 0;
            fail_count <= 0;
            pending <= 0;
            results_checked <= 0;
            explored_seen <= 0;
        end
        else
        begin
            if (done)
            begin
                check_result(result);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_EXPLORE_THRESHOLD: explore_level = cfg_data;
                    CFG_LEARN_RATE:        learn_gain = cfg_data;
                    CFG_DISCOUNT:          discount_gain = cfg_data;
                    default:               ;
                endcase
            end
            if (start && !busy)
            begin
                predict(request);
            end
            fail_count <= failures;
            pending <= victims_due.size();
            results_checked <= results_seen;
            explored_seen <= explored_count;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: regression for the Q-learning victim selector
// Drives a short directed set of choose and update beats, then bursts of
// random beats, most aimed at one occupancy row at a time, under several
// coefficient settings and sender idle patterns. The checker judges results.
// ----------------------------------------------------------------------------
module testbench;

    import qlvs_pkg::*;

    localparam int WAYS          = WAYS_DEFAULT;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    request_t               request = '0;
    logic                   done;
    result_t                result;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]      cfg_data = '0;
    int unsigned            fail_count;
    int unsigned            pending;
    int unsigned            results_checked;
    int unsigned            explored_seen;
    int unsigned            cycles = 0;
    int unsigned            chooses_sent = 0;
    int unsigned            updates_sent = 0;
    int unsigned            settings_used = 0;
    int unsigned            idle_pct = 0;

    always #6 clk = ~clk;

    q_learning_victim_selector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qlvs_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request         (request),
        .done            (done),
        .result          (result),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .explored_seen   (explored_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic request_t beat_of(input logic op, input logic [15:0] mask,
                                         input logic [3:0] way, input logic hit);
        request_t b;
        b.opcode = op;
        b.valid_mask = mask;
        b.way = way;
        b.hit = hit;
        return b;
    endfunction

    function automatic logic [15:0] mask_with(input int unsigned ones);
        logic [15:0] m;
        m = '0;
        while ($countones(m) < ones)
        begin
            m[$urandom_range(WAYS - 1)] = 1'b1;
        end
        return m;
    endfunction

    task automatic send_beat(input request_t beat);
        request <= beat;
        do
        begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
        end
        while (!(start && !busy));
        if (beat.opcode == OP_CHOOSE)
        begin
            chooses_sent++;
        end
        else
        begin
            updates_sent++;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_coefs(input logic [COEF_W-1:0] epsilon_q,
                              input logic [COEF_W-1:0] alpha_q,
                              input logic [COEF_W-1:0] gamma_q);
        cfg_write <= 1'b1;
        cfg_index <= CFG_EXPLORE_THRESHOLD;
        cfg_data <= epsilon_q;
        @(posedge clk);
        cfg_index <= CFG_LEARN_RATE;
        cfg_data <= alpha_q;
        @(posedge clk);
        cfg_index <= CFG_DISCOUNT;
        cfg_data <= gamma_q;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data <= 16'($urandom_range(16'hFFFF));
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int unsigned beats, input int unsigned idle);
        int unsigned sent;
        int unsigned burst;
        int unsigned row;
        int unsigned bias;
        request_t    beat;
        idle_pct = idle;
        sent = 0;
        while (sent < beats)
        begin
            burst = $urandom_range(8, 40);
            row = $urandom_range(0, WAYS);
            bias = $urandom_range(2);
            for (int i = 0; i < burst && sent < beats; i++)
            begin
                if ($urandom_range(99) < 12)
                begin
                    beat.opcode = 1'($urandom_range(1));
                    beat.valid_mask = 16'($urandom_range(16'hFFFF));
                    beat.way = 4'($urandom_range(15));
                    beat.hit = 1'($urandom_range(1));
                end
                else
                begin
                    beat.opcode = ($urandom_range(99) < 40) ? OP_CHOOSE : OP_UPDATE;
                    beat.valid_mask = mask_with(row);
                    beat.way = 4'($urandom_range(WAYS - 1));
                    case (bias)
                        0:       beat.hit = ($urandom_range(9) == 0);
                        1:       beat.hit = ($urandom_range(9) != 0);
                        default: beat.hit = 1'($urandom_range(1));
                    endcase
                end
                send_beat(beat);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(beat_of(OP_CHOOSE, 16'h0000, 4'd0, 1'b0));
        send_beat(beat_of(OP_CHOOSE, 16'hFFFF, 4'd15, 1'b1));
        send_beat(beat_of(OP_UPDATE, 16'hFFFF, 4'd15, 1'b1));
        send_beat(beat_of(OP_UPDATE, 16'hFFFF, 4'd0, 1'b0));
        send_beat(beat_of(OP_CHOOSE, 16'hFFFF, 4'd0, 1'b0));
        send_beat(beat_of(OP_UPDATE, 16'h0000, 4'd7, 1'b1));
        send_beat(beat_of(OP_UPDATE, 16'h0000, 4'd3, 1'b1));
        send_beat(beat_of(OP_CHOOSE, 16'h0000, 4'd15, 1'b1));
        send_beat(beat_of(OP_UPDATE, 16'h8001, 4'd15, 1'b0));
        send_beat(beat_of(OP_UPDATE, 16'h0180, 4'd8, 1'b0));
        send_beat(beat_of(OP_CHOOSE, 16'h4002, 4'd0, 1'b0));
        send_beat(beat_of(OP_CHOOSE, 16'h1000, 4'd0, 1'b0));
        send_beat(beat_of(OP_UPDATE, 16'hAAAA, 4'd10, 1'b1));
        send_beat(beat_of(OP_UPDATE, 16'h5555, 4'd5, 1'b1));
        send_beat(beat_of(OP_UPDATE, 16'h00FF, 4'd5, 1'b1));
        send_beat(beat_of(OP_CHOOSE, 16'hFF00, 4'd9, 1'b1));
        send_beat(beat_of(OP_CHOOSE, 16'h0F0F, 4'd0, 1'b0));
        drain();

        load_coefs(16'd0, 16'hFFFF, 16'hFFFF);
        run_phase(105, 0);
        drain();
        load_coefs(16'hFFFF, 16'd0, 16'd0);
        run_phase(105, 52);
        drain();
        load_coefs(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                   16'($urandom_range(16'hFFFF)));
        run_phase(105, 0);
        drain();
        load_coefs(EXPLORE_THRESHOLD_RESET, 16'h8000, DISCOUNT_RESET);
        run_phase(105, 7);
        drain();
        load_coefs(16'd3000, 16'hFFFF, 16'd0);
        run_phase(105, 52);
        drain();
        load_coefs(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                   16'($urandom_range(16'hFFFF)));
        run_phase(105, 7);
        drain();

        $display("covered %0d choose and %0d update beats under %0d coefficient loads",
                 chooses_sent, updates_sent, settings_used);
        $display("compared %0d victims, %0d explored and %0d greedy",
                 results_checked, explored_seen, results_checked - explored_seen);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== q_learning_victim_selector.f =====
hw/rtl/qlvs_pkg.sv
hw/rtl/qlvs_mulrnd.sv
hw/rtl/q_learning_victim_selector.sv
sim/qlvs_checker.sv
sim/testbench.sv
